// ===== rtl/dmpr_pkg.sv =====
// Shared types, constants and handshake structs of the dual motor PWM ramp and pulse unit.
package dmpr_pkg;

    localparam int W_DUTY  = 10;
    localparam int W_SPEED = 11;
    localparam int W_GAIN  = 16;
    localparam int W_LEN   = 6;
    localparam int W_VAL   = 13;
    localparam int W_INC   = 12;
    localparam int W_MAG   = 11;
    localparam int W_PROD  = W_MAG + W_GAIN;
    localparam int Q_FRAC  = 14;

    localparam int DUTY_TOP_VAL         = 1000;
    localparam int DEF_MAX_PULSE_PERIOD = 32;
    localparam int DIV_STEPS            = W_MAG;
    localparam int W_CNT                = $clog2(DIV_STEPS);

    localparam logic [W_DUTY-1:0] DUTY_TOP       = W_DUTY'(DUTY_TOP_VAL);
    localparam logic [W_GAIN-1:0] GAIN_RESET     = 16'd16384;
    localparam logic [W_DUTY-1:0] RAMP_STEP_RESET = 10'd5;

    // register index, taken from the word address
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_STEP = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_DRIVE  = 2'd1,
        OP_DIRECT = 2'd2,
        OP_PULSE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_MUL,
        ST_WRITE,
        ST_PINIT,
        ST_DIV,
        ST_PFIN
    } t_state;

    typedef struct packed {
        logic load;
        logic tick;
        logic mul;
        logic write;
        logic motor;
        logic pinit;
        logic div_step;
        logic pfin;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/dmpr_ctrl.sv =====
// Sequencer of the dual motor PWM ramp and pulse unit.
module dmpr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  dmpr_pkg::t_op  i_op,
    input  dmpr_pkg::t_stat i_stat,
    output logic           o_ready,
    output dmpr_pkg::t_cmd o_cmd
);
    import dmpr_pkg::*;

    t_state             r_state, n_state;
    logic               r_motor, n_motor;
    logic [W_CNT-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_motor <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_motor <= n_motor;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_motor = r_motor;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_motor = 1'b0;
                n_cnt   = '0;
                if (i_valid) begin
                    case (i_op)
                        OP_TICK:              n_state = ST_TICK;
                        OP_DRIVE, OP_DIRECT:  n_state = ST_MUL;
                        OP_PULSE:             n_state = ST_PINIT;
                        default:              n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TICK: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            ST_MUL:   n_state = ST_WRITE;
            ST_WRITE: begin
                if (r_motor) begin
                    n_state = ST_IDLE;
                end else begin
                    n_motor = 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_PINIT: n_state = ST_DIV;
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == W_CNT'(DIV_STEPS - 1)) n_state = ST_PFIN;
            end
            ST_PFIN:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = (r_state == ST_IDLE);
        o_cmd          = '0;
        o_cmd.load     = (r_state == ST_IDLE) && i_valid;
        o_cmd.tick     = (r_state == ST_TICK) && i_stat.out_free;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.write    = (r_state == ST_WRITE);
        o_cmd.motor    = r_motor;
        o_cmd.pinit    = (r_state == ST_PINIT);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.pfin     = (r_state == ST_PFIN);
    end

endmodule

// ===== rtl/dmpr_dp.sv =====
// Datapath of the dual motor PWM ramp and pulse unit: duty store, scaler, divider, wave.
module dmpr_dp #(
    parameter int MAX_PULSE_PERIOD = dmpr_pkg::DEF_MAX_PULSE_PERIOD
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dmpr_pkg::t_cmd                   i_cmd,
    output dmpr_pkg::t_stat                  o_stat,
    input  logic [dmpr_pkg::W_GAIN-1:0]      i_gain,
    input  logic [dmpr_pkg::W_DUTY-1:0]      i_ramp_step,
    input  logic [dmpr_pkg::W_SPEED-1:0]     i_speed1,
    input  logic [dmpr_pkg::W_SPEED-1:0]     i_speed2,
    input  logic [dmpr_pkg::W_DUTY-1:0]      i_pulse_low,
    input  logic [dmpr_pkg::W_DUTY-1:0]      i_pulse_high,
    input  logic [dmpr_pkg::W_LEN-1:0]       i_pulse_length,
    input  logic                             i_pulse_forward,
    input  logic                             i_direct,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [4*dmpr_pkg::W_DUTY-1:0]    o_out_duty,
    output logic                             o_out_pulse
);
    import dmpr_pkg::*;

    localparam int W_PER = $clog2(MAX_PULSE_PERIOD + 1);
    localparam int W_IDX = (MAX_PULSE_PERIOD > 1) ? $clog2(MAX_PULSE_PERIOD) : 1;
    localparam int W_SAT = (W_PER > W_LEN) ? W_PER : W_LEN;
    localparam int W_EXT = W_VAL + 1;

    function automatic logic [W_DUTY-1:0] sat_top(input logic [W_DUTY-1:0] x);
        return (x > DUTY_TOP) ? DUTY_TOP : x;
    endfunction

    // latched item
    logic [W_SPEED-1:0] r_sp1, r_sp2;
    logic [W_DUTY-1:0]  r_plow, r_phigh;
    logic [W_LEN-1:0]   r_plen;
    logic               r_pfwd, r_direct;

    // duty store
    logic [W_DUTY-1:0]  r_cur [4];
    logic [W_DUTY-1:0]  r_tgt [4];
    logic [W_DUTY-1:0]  n_cur [4];

    // scaler
    logic [W_PROD-1:0]  r_prod;
    logic               r_pos;

    // pulse wave
    logic               r_pmode, r_pdir, r_falling, r_neg;
    logic [W_IDX-1:0]   r_idx;
    logic [W_PER-1:0]   r_period;
    logic [W_VAL-1:0]   r_val;
    logic [W_INC-1:0]   r_inc;
    logic [W_DUTY-1:0]  r_pmin, r_pmax;

    // divider
    logic [W_PER:0]     r_rem;
    logic [W_MAG-1:0]   r_quo;

    // output register
    logic               r_ovalid;
    logic [W_DUTY-1:0]  r_odut [4];
    logic               r_opulse;

    // scaler inputs
    logic [W_SPEED-1:0] sel_sp;
    logic [W_MAG-1:0]   sel_mag;
    logic [W_PROD-Q_FRAC-1:0] scaled;
    logic [W_DUTY-1:0]  sat_mag, drv_f, drv_r;

    always_comb begin
        sel_sp  = i_cmd.motor ? r_sp2 : r_sp1;
        sel_mag = sel_sp[W_SPEED-1] ? W_MAG'(~sel_sp + 1'b1) : W_MAG'(sel_sp);
        scaled  = r_prod[W_PROD-1:Q_FRAC];
        sat_mag = (scaled > (W_PROD-Q_FRAC)'(DUTY_TOP_VAL)) ? DUTY_TOP : scaled[W_DUTY-1:0];
        drv_f   = r_pos ? sat_mag : '0;
        drv_r   = r_pos ? '0 : sat_mag;
    end

    // pulse start arithmetic
    logic [W_DUTY-1:0]        lo_sat, hi_sat;
    logic signed [W_DUTY:0]   diff;
    logic signed [W_INC-1:0]  diff2;
    logic [W_MAG-1:0]         diff_mag;
    logic [W_SAT-1:0]         len_in, len_sat;

    always_comb begin
        lo_sat   = sat_top(r_plow);
        hi_sat   = sat_top(r_phigh);
        diff     = $signed({1'b0, hi_sat}) - $signed({1'b0, lo_sat});
        diff2    = {diff, 1'b0};
        diff_mag = diff2[W_INC-1] ? W_MAG'(-diff2) : W_MAG'(diff2);
        len_in   = W_SAT'(r_plen);
        if (len_in == '0)                            len_sat = W_SAT'(1);
        else if (len_in > W_SAT'(MAX_PULSE_PERIOD))  len_sat = W_SAT'(MAX_PULSE_PERIOD);
        else                                         len_sat = len_in;
    end

    // one restoring division step
    logic [W_PER:0] rem_sh;
    logic           div_ge;
    always_comb begin
        rem_sh = {r_rem[W_PER-1:0], r_quo[W_MAG-1]};
        div_ge = (rem_sh >= {1'b0, r_period});
    end

    // wave advance
    logic [W_PER-1:0]        idx_nx;
    logic                    wrap;
    logic signed [W_EXT-1:0] inc_ext, val_ext, max_ext, nv, mirror;
    logic [W_DUTY-1:0]       pv;

    always_comb begin
        idx_nx  = W_PER'(r_idx) + 1'b1;
        wrap    = (idx_nx >= r_period);
        inc_ext = W_EXT'(signed'(r_inc));
        val_ext = W_EXT'(signed'(r_val));
        max_ext = $signed(W_EXT'(r_pmax));
        nv      = r_falling ? (val_ext - inc_ext) : (val_ext + inc_ext);
        mirror  = $signed(W_EXT'({r_pmax, 1'b0})) - nv;
        // clamp the emitted sample to the duty range
        if (r_val[W_VAL-1])                         pv = '0;
        else if (r_val > W_VAL'(DUTY_TOP_VAL))      pv = DUTY_TOP;
        else                                        pv = r_val[W_DUTY-1:0];
    end

    // slew of all four channels toward their targets
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_cur[i] < r_tgt[i]) begin
                n_cur[i] = ((r_tgt[i] - r_cur[i]) > i_ramp_step) ?
                           (r_cur[i] + i_ramp_step) : r_tgt[i];
            end else if (r_cur[i] > r_tgt[i]) begin
                n_cur[i] = ((r_cur[i] - r_tgt[i]) > i_ramp_step) ?
                           (r_cur[i] - i_ramp_step) : r_tgt[i];
            end else begin
                n_cur[i] = r_cur[i];
            end
        end
    end

    assign o_stat.out_free = !r_ovalid || i_out_ready;

    // item latch, scaler product, divider and output duties
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sp1    <= i_speed1;
            r_sp2    <= i_speed2;
            r_plow   <= i_pulse_low;
            r_phigh  <= i_pulse_high;
            r_plen   <= i_pulse_length;
            r_pfwd   <= i_pulse_forward;
            r_direct <= i_direct;
        end
        if (i_cmd.mul) begin
            r_prod <= sel_mag * i_gain;
            r_pos  <= !sel_sp[W_SPEED-1] && (sel_sp != '0);
        end
        if (i_cmd.pinit) begin
            r_rem <= '0;
            r_quo <= diff_mag;
            r_neg <= diff2[W_INC-1];
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? (rem_sh - {1'b0, r_period}) : rem_sh;
            r_quo <= {r_quo[W_MAG-2:0], div_ge};
        end
        if (i_cmd.tick) begin
            r_opulse <= r_pmode;
            for (int i = 0; i < 4; i++) begin
                if (r_pmode) begin
                    r_odut[i] <= (r_pdir == !i[0]) ? pv : '0;
                end else begin
                    r_odut[i] <= n_cur[i];
                end
            end
        end
    end

    // duty store, wave state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
            r_pmode   <= 1'b0;
            r_pdir    <= 1'b0;
            r_idx     <= '0;
            r_period  <= W_PER'(1);
            r_val     <= '0;
            r_falling <= 1'b0;
            r_inc     <= '0;
            r_pmin    <= '0;
            r_pmax    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.tick) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.write) begin
                r_pmode <= 1'b0;
                r_tgt[{i_cmd.motor, 1'b0}] <= drv_f;
                r_tgt[{i_cmd.motor, 1'b1}] <= drv_r;
                if (r_direct) begin
                    r_cur[{i_cmd.motor, 1'b0}] <= drv_f;
                    r_cur[{i_cmd.motor, 1'b1}] <= drv_r;
                end
            end
            if (i_cmd.pinit) begin
                r_pmin    <= lo_sat;
                r_pmax    <= hi_sat;
                r_period  <= len_sat[W_PER-1:0];
                r_val     <= W_VAL'(lo_sat);
                r_falling <= 1'b0;
                r_idx     <= '0;
                r_pdir    <= r_pfwd;
            end
            if (i_cmd.pfin) begin
                r_inc   <= r_neg ? -{1'b0, r_quo} : {1'b0, r_quo};
                r_pmode <= 1'b1;
            end
            if (i_cmd.tick) begin
                if (r_pmode) begin
                    if (wrap) begin
                        r_idx     <= '0;
                        r_val     <= W_VAL'(r_pmin);
                        r_falling <= 1'b0;
                    end else begin
                        r_idx <= idx_nx[W_IDX-1:0];
                        if (nv > max_ext) begin
                            r_val     <= mirror[W_VAL-1:0];
                            r_falling <= 1'b1;
                        end else begin
                            r_val <= nv[W_VAL-1:0];
                        end
                    end
                end else begin
                    for (int i = 0; i < 4; i++) r_cur[i] <= n_cur[i];
                end
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_duty  = {r_odut[3], r_odut[2], r_odut[1], r_odut[0]};
    assign o_out_pulse = r_opulse;

endmodule

// ===== rtl/dual_motor_pwm_ramp_pulse_unit.sv =====
// Top level of the dual motor PWM ramp and pulse unit: ports, registers, checks.
//
// Four-channel duty generator for two H-bridge motors (channel order: motor 1
// forward, motor 1 reverse, motor 2 forward, motor 2 reverse). The item kind in
// s_axis_tuser selects one of four operations. A tick produces one result item:
// in normal mode every current duty first slews toward its target by at most
// ramp_step, in pulse mode one sample of the triangle wave goes out on the
// forward or reverse channels of both motors and m_axis_tuser is set. A ramped
// or direct drive scales both signed speeds by the Q2.14 compensation gain,
// saturates at 1000, sets the targets (direct also sets the current duties) and
// ends pulse mode; it gives no result. A pulse start loads the wave and gives no
// result. After acceptance, a tick waits while a previous result still sits in
// the output register; a drive multiplies, then saturates and writes, for one
// motor at a time on one shared 11x16 multiplier; a pulse start runs the
// restoring divider that forms the wave increment one quotient bit per cycle.
// Results wait in an output register, so a new item is taken while the last
// result is still unclaimed. The APB registers (gain at 0x0, ramp step at
// 0x4) are to be written only while the block is idle.
module dual_motor_pwm_ramp_pulse_unit #(
    parameter int MAX_PULSE_PERIOD = dmpr_pkg::DEF_MAX_PULSE_PERIOD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // motor1_speed[10:0], motor2_speed[21:11], pulse_low[31:22], pulse_high[41:32],
    // pulse_length[47:42], pulse_forward[48], zero fill[55:49]
    input  logic [55:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // duty_m1_fwd[9:0], duty_m1_rev[19:10], duty_m2_fwd[29:20], duty_m2_rev[39:30]
    output logic [39:0] m_axis_tdata,
    // pulse_active[0]
    output logic        m_axis_tuser
);
    import dmpr_pkg::*;

    logic [W_GAIN-1:0] r_gain;
    logic [W_DUTY-1:0] r_step;
    logic              cfg_wr;
    t_cmd              cmd;
    t_stat             stat;
    t_op               op;

    // configuration registers; write on the APB access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_step <= RAMP_STEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_GAIN) r_gain <= pwdata[W_GAIN-1:0];
            if (paddr[2] == REG_STEP) r_step <= pwdata[W_DUTY-1:0];
        end
    end

    // read back the addressed register
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_GAIN) prdata = 32'(r_gain);
        else                      prdata = 32'(r_step);
    end

    assign op = t_op'(s_axis_tuser);

    dmpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (op),
        .i_stat  (stat),
        .o_ready (s_axis_tready),
        .o_cmd   (cmd)
    );

    dmpr_dp #(
        .MAX_PULSE_PERIOD (MAX_PULSE_PERIOD)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_gain          (r_gain),
        .i_ramp_step     (r_step),
        .i_speed1        (s_axis_tdata[10:0]),
        .i_speed2        (s_axis_tdata[21:11]),
        .i_pulse_low     (s_axis_tdata[31:22]),
        .i_pulse_high    (s_axis_tdata[41:32]),
        .i_pulse_length  (s_axis_tdata[47:42]),
        .i_pulse_forward (s_axis_tdata[48]),
        .i_direct        (op == OP_DIRECT),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_out_duty      (m_axis_tdata),
        .o_out_pulse     (m_axis_tuser)
    );

    // an accepted item keeps the sequencer busy, so input ready is low in the cycle after it
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // no duty above the top value
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:0] <= DUTY_TOP) && (m_axis_tdata[19:10] <= DUTY_TOP)
        && (m_axis_tdata[29:20] <= DUTY_TOP) && (m_axis_tdata[39:30] <= DUTY_TOP))
        else $error("duty above top value");

    // pulse samples drive both motors alike and only one channel of each
    a_pulse_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (m_axis_tdata[9:0] == m_axis_tdata[29:20]) && (m_axis_tdata[19:10] == m_axis_tdata[39:30])
        && ((m_axis_tdata[9:0] == '0) || (m_axis_tdata[19:10] == '0)))
        else $error("pulse sample on both channels or motors differ");

endmodule

// ===== verif/dmpr_duty_checker.sv =====
// Checker for the dual motor PWM unit: duty prediction and result comparison.
module dmpr_duty_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic        i_m_tuser,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dmpr_pkg::*;

    typedef struct packed {
        logic [W_DUTY-1:0] m1_fwd;
        logic [W_DUTY-1:0] m1_rev;
        logic [W_DUTY-1:0] m2_fwd;
        logic [W_DUTY-1:0] m2_rev;
        logic              active;
    } t_duty_set;

    t_duty_set   predicted_duties[$];
    t_duty_set   want;

    // mirror of the block's registers and state
    int unsigned gain_q14;
    int unsigned ramp_inc;
    int unsigned cur_duty[4];
    int unsigned tgt_duty[4];
    bit          pulsing;
    bit          pulse_fwd;
    bit          wave_falling;
    int          wave_idx;
    int          wave_len;
    int          wave_val;
    int          wave_inc;
    int          wave_lo;
    int          wave_hi;

    task automatic reset_model();
        gain_q14     = GAIN_RESET;
        ramp_inc     = RAMP_STEP_RESET;
        cur_duty     = '{default: 0};
        tgt_duty     = '{default: 0};
        pulsing      = 1'b0;
        pulse_fwd    = 1'b0;
        wave_falling = 1'b0;
        wave_idx     = 0;
        wave_len     = 1;
        wave_val     = 0;
        wave_inc     = 0;
        wave_lo      = 0;
        wave_hi      = 0;
    endtask

    function automatic int unsigned slew(input int unsigned cur, input int unsigned tgt);
        if (cur < tgt) return (tgt - cur > ramp_inc) ? cur + ramp_inc : tgt;
        if (cur > tgt) return (cur - tgt > ramp_inc) ? cur - ramp_inc : tgt;
        return cur;
    endfunction

    // scale, saturate and steer one motor speed onto its channel pair
    task automatic steer_motor(input int base, input logic [W_SPEED-1:0] raw, input bit direct);
        int          spd;
        int unsigned mag;
        int unsigned fwd;
        int unsigned rev;
        spd = $signed(raw);
        mag = (spd < 0) ? -spd : spd;
        mag = (mag * gain_q14) >> Q_FRAC;
        if (mag > DUTY_TOP_VAL) mag = DUTY_TOP_VAL;
        if (spd > 0 && mag != 0) begin
            fwd = mag;
            rev = 0;
        end else begin
            fwd = 0;
            rev = mag;
        end
        tgt_duty[base]     = fwd;
        tgt_duty[base + 1] = rev;
        if (direct) begin
            cur_duty[base]     = fwd;
            cur_duty[base + 1] = rev;
        end
    endtask

    task automatic advance_duty_model(input t_op op, input logic [55:0] d);
        t_duty_set res;
        int        len;
        int        v;
        case (op)
            OP_DRIVE, OP_DIRECT: begin
                pulsing = 1'b0;
                steer_motor(0, d[10:0], op == OP_DIRECT);
                steer_motor(2, d[21:11], op == OP_DIRECT);
            end
            OP_PULSE: begin
                len = d[47:42];
                if (len == 0) len = 1;
                if (len > DEF_MAX_PULSE_PERIOD) len = DEF_MAX_PULSE_PERIOD;
                wave_lo      = d[31:22];
                wave_hi      = d[41:32];
                if (wave_lo > DUTY_TOP_VAL) wave_lo = DUTY_TOP_VAL;
                if (wave_hi > DUTY_TOP_VAL) wave_hi = DUTY_TOP_VAL;
                wave_len     = len;
                wave_inc     = (2 * (wave_hi - wave_lo)) / len;
                wave_val     = wave_lo;
                wave_falling = 1'b0;
                wave_idx     = 0;
                pulse_fwd    = d[48];
                pulsing      = 1'b1;
            end
            default: begin
                if (pulsing) begin
                    v = (wave_val < 0) ? 0 : (wave_val > DUTY_TOP_VAL) ? DUTY_TOP_VAL : wave_val;
                    res.m1_fwd = pulse_fwd ? W_DUTY'(v) : '0;
                    res.m1_rev = pulse_fwd ? '0 : W_DUTY'(v);
                    res.m2_fwd = res.m1_fwd;
                    res.m2_rev = res.m1_rev;
                    res.active = 1'b1;
                    wave_idx++;
                    if (wave_idx >= wave_len) begin
                        wave_idx     = 0;
                        wave_val     = wave_lo;
                        wave_falling = 1'b0;
                    end else begin
                        wave_val += wave_falling ? -wave_inc : wave_inc;
                        // fold back at the peak and fall from there
                        if (wave_val > wave_hi) begin
                            wave_val     = 2 * wave_hi - wave_val;
                            wave_falling = 1'b1;
                        end
                    end
                end else begin
                    for (int i = 0; i < 4; i++) cur_duty[i] = slew(cur_duty[i], tgt_duty[i]);
                    res.m1_fwd = W_DUTY'(cur_duty[0]);
                    res.m1_rev = W_DUTY'(cur_duty[1]);
                    res.m2_fwd = W_DUTY'(cur_duty[2]);
                    res.m2_rev = W_DUTY'(cur_duty[3]);
                    res.active = 1'b0;
                end
                predicted_duties.push_back(res);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            predicted_duties.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_STEP) ramp_inc = i_pwdata[W_DUTY-1:0];
                else                        gain_q14 = i_pwdata[W_GAIN-1:0];
            end
            // results leave before the item taken at the same edge can cause one
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_duties.size() == 0) begin
                    $error("result item with nothing expected: tdata %h tuser %b",
                           i_m_tdata, i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = predicted_duties.pop_front();
                    check_field("duty_m1_fwd", 16'(want.m1_fwd), 16'(i_m_tdata[9:0]));
                    check_field("duty_m1_rev", 16'(want.m1_rev), 16'(i_m_tdata[19:10]));
                    check_field("duty_m2_fwd", 16'(want.m2_fwd), 16'(i_m_tdata[29:20]));
                    check_field("duty_m2_rev", 16'(want.m2_rev), 16'(i_m_tdata[39:30]));
                    check_field("pulse_active", 16'(want.active), 16'(i_m_tuser));
                end
            end
            if (i_s_tvalid && i_s_tready) advance_duty_model(t_op'(i_s_tuser), i_s_tdata);
        end
        o_pending = predicted_duties.size();
    end

endmodule

// ===== verif/dual_motor_pwm_ramp_pulse_unit_tb.sv =====
// Testbench top of the dual motor PWM unit: stimulus, idling, run verdict.
module dual_motor_pwm_ramp_pulse_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dmpr_pkg::*;

    // byte addresses of the two registers, one word apart
    localparam logic [2:0] ADDR_GAIN = {REG_GAIN, 2'b00};
    localparam logic [2:0] ADDR_STEP = {REG_STEP, 2'b00};

    // cycles to let pass after the last expected result before a register write:
    // a pulse start produces nothing to wait for
    localparam int QUIET_CYCLES = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int pending;

    // idle_allowed closes all idling for the final stretch; stall_en is redrawn per sequence
    bit idle_allowed;
    bit stall_en;

    dual_motor_pwm_ramp_pulse_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dmpr_duty_checker duty_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run (every item behind the longest
    // input gap, every result behind the longest receiver stall).
    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Pack one input item; the fill bits above pulse_forward stay zero.
    function automatic logic [55:0] pack_fields(input logic [10:0] m1, input logic [10:0] m2,
                                                input logic [9:0] lo, input logic [9:0] hi,
                                                input logic [5:0] len, input logic fwd);
        return {7'b0, fwd, len, hi, lo, m2, m1};
    endfunction

    // Mostly legal speeds, now and then any 11-bit pattern (down to -1024).
    function automatic logic [10:0] rand_speed();
        if ($urandom_range(0, 3) == 0) return 11'($urandom);
        return 11'(int'($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic logic [9:0] rand_bound();
        if ($urandom_range(0, 6) == 0) return 10'($urandom);
        return 10'($urandom_range(0, 1000));
    endfunction

    function automatic logic [5:0] rand_len();
        if ($urandom_range(0, 6) == 0) return 6'($urandom);
        return 6'($urandom_range(1, 32));
    endfunction

    function automatic logic [55:0] rand_fields();
        return pack_fields(rand_speed(), rand_speed(), rand_bound(), rand_bound(),
                           rand_len(), 1'($urandom));
    endfunction

    // Two-phase APB write: setup, then access until pready.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one item, maybe after an idle burst, and hold it until taken.
    task automatic send_item(input t_op op, input logic [55:0] fields);
        @(negedge i_clk);
        if (stall_en && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_axis_tdata  = fields;
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, rand_fields());
    endtask

    // Drain outstanding results, then let a silent pulse start finish too.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (QUIET_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed runs: a command followed by ticks that walk the ramp or
    // the wave; the rest is single items with random kind and content.
    task automatic run_random(input int n_items);
        int        sent;
        int        kind;
        int        ticks;
        int        eff_len;
        logic [5:0] len;
        sent = 0;
        while (sent < n_items) begin
            stall_en = idle_allowed && ($urandom_range(0, 4) != 0);
            kind     = $urandom_range(0, 9);
            if (kind < 4) begin
                len = rand_len();
                send_item(OP_PULSE, pack_fields(rand_speed(), rand_speed(), rand_bound(),
                                                rand_bound(), len, 1'($urandom)));
                eff_len = (len == 0) ? 1 : (len > DEF_MAX_PULSE_PERIOD) ?
                          DEF_MAX_PULSE_PERIOD : len;
                ticks   = $urandom_range(1, 2 * eff_len + 2);
            end else if (kind < 8) begin
                send_item(($urandom_range(0, 2) == 0) ? OP_DIRECT : OP_DRIVE, rand_fields());
                ticks = $urandom_range(1, 30);
            end else begin
                send_item(t_op'($urandom_range(0, 3)), rand_fields());
                ticks = 0;
            end
            send_ticks(ticks);
            sent += ticks + 1;
        end
    endtask

    // Receiver side: stall in random bursts while idling is allowed.
    initial begin
        m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_en && $urandom_range(0, 6) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    initial begin
        int gain_val;
        int step_val;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_TICK;
        idle_allowed  = 1'b1;
        stall_en      = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset settings (unity gain, step of 5).
        // Tick straight out of reset: all duties zero.
        send_item(OP_TICK, '0);
        // Direct drive at full legal speed both ways, then the 11-bit extremes.
        send_item(OP_DIRECT, pack_fields(11'sd1000, -11'sd1000, '0, '0, '0, 1'b0));
        send_item(OP_TICK, '0);
        send_item(OP_DIRECT, pack_fields(-11'sd1024, 11'sd1023, '0, '0, '0, 1'b0));
        send_item(OP_TICK, '0);
        // Ramped drive to zero: both channels head to 0 at the step rate.
        send_item(OP_DRIVE, pack_fields('0, '0, '0, '0, '0, 1'b0));
        send_ticks(2);
        // Smallest nonzero speeds in each direction.
        send_item(OP_DRIVE, pack_fields(11'sd1, -11'sd1, '0, '0, '0, 1'b0));
        send_item(OP_TICK, '0);
        // Full-swing forward pulse over four ticks, run past one period.
        send_item(OP_PULSE, pack_fields('0, '0, 10'd0, 10'd1000, 6'd4, 1'b1));
        send_ticks(5);
        // Low above high with out-of-range low and zero length (taken as one).
        send_item(OP_PULSE, pack_fields('0, '0, 10'd1023, 10'd0, 6'd0, 1'b0));
        send_ticks(2);
        // Restart while pulsing, length past the maximum, high above the top.
        send_item(OP_PULSE, pack_fields('0, '0, 10'd200, 10'd1023, 6'd63, 1'b1));
        send_ticks(3);
        // A drive ends pulse mode; the next tick ramps again.
        send_item(OP_DRIVE, pack_fields(11'sd500, -11'sd500, '0, '0, '0, 1'b0));
        send_item(OP_TICK, '0);

        // Random phases, each with its own register setting; extremes first.
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin
                    gain_val = 65535;
                    step_val = 1000;
                end
                1: begin
                    gain_val = 0;
                    step_val = 0;
                end
                2: begin
                    gain_val = 16384;
                    step_val = 1;
                end
                3: begin
                    gain_val = $urandom_range(0, 65535);
                    step_val = 1023;
                end
                default: begin
                    gain_val = $urandom_range(0, 65535);
                    step_val = $urandom_range(1, 40);
                end
            endcase
            write_reg(ADDR_GAIN, gain_val);
            write_reg(ADDR_STEP, step_val);
            // no idling on either side in the final phase
            idle_allowed = (ph != 7);
            run_random(205);
        end

        // Drop valid, wait out every expected result, then a short quiet spell.
        stall_en = 1'b0;
        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
